// File: rtl/core/pfr_pkg.sv
// Package with shared types and constants of the page framebuffer refresh block.
package pfr_pkg;

  localparam int unsigned DefColumns = 128;
  localparam int unsigned DefPages   = 8;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [7:0] PageCmdBaseRst = 8'd176;
  localparam logic [7:0] ColLowCmdRst   = 8'd2;
  localparam logic [7:0] ColHighCmdRst  = 8'd16;
  localparam logic [7:0] FillOnes       = 8'hff;

  typedef enum logic [1:0] {
    CMD_WRITE_PIXEL = 2'd0,
    CMD_FILL        = 2'd1,
    CMD_REFRESH     = 2'd2,
    CMD_TICK        = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAGE_CMD_BASE = 2'd0,
    CFG_COL_LOW_CMD   = 2'd1,
    CFG_COL_HIGH_CMD  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0] command;
    logic [6:0] pixel_x;
    logic [5:0] pixel_y;
    logic       color;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       frame_end;
  } out_item_t;

endpackage

// File: rtl/core/page_framebuffer_refresh_top.sv
// Page-organized monochrome frame store with a byte-serial refresh stream.
// A tick taken during a refresh waits in ST_TICK until the output register is free, then fills it.
// A pixel write or a refresh tick runs in two steps (read, then write back or emit), the emit waiting
// while the output register is held; a refresh start or an idle tick never leaves the idle state.
// A fill request stalls the input while it sweeps all PAGES*COLUMNS bytes of the store.
// Reset clears control state and runs a pass over all PAGES*COLUMNS bytes (1024 by default)
// that zeroes the store; configuration writes are taken during that pass.
module page_framebuffer_refresh_top #(
  parameter int unsigned COLUMNS = pfr_pkg::DefColumns,
  parameter int unsigned PAGES   = pfr_pkg::DefPages
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pfr_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pfr_pkg::out_item_t            out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pfr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [7:0]                    cfg_data_i
);
  import pfr_pkg::*;

  // Store geometry. The store holds PAGES rows of COLUMNS bytes.
  localparam int unsigned Depth  = PAGES * COLUMNS;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned PageW  = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned Slots  = COLUMNS + 3;
  localparam int unsigned SlotW  = $clog2(Slots);

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_PIX,
    ST_TICK
  } state_e;

  // Control and datapath registers.
  state_e            state_q, state_d;
  logic [7:0]        fill_q, fill_d;
  logic [AddrW-1:0]  sweep_q, sweep_d;
  logic              active_q, active_d;
  logic [PageW-1:0]  page_q, page_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [7:0]        pend_byte_q, pend_byte_d;
  logic              pend_data_q, pend_data_d;
  logic              pend_end_q, pend_end_d;
  logic [AddrW-1:0]  pix_addr_q, pix_addr_d;
  logic [2:0]        pix_bit_q, pix_bit_d;
  logic              pix_color_q, pix_color_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q, out_item_d;
  logic [7:0]        page_base_q, col_low_q, col_high_q;

  // Frame store port.
  logic [7:0]        mem_q [Depth];
  logic [7:0]        rdata_q;
  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_addr;
  logic [7:0]        mem_wdata;

  logic              in_take;
  logic [2:0]        req_page;
  logic              pix_in_range;
  logic [AddrW-1:0]  req_pix_addr;
  logic [AddrW-1:0]  tick_addr;
  logic [7:0]        pix_mask;
  logic              out_free;
  logic              last_slot;
  logic              last_page;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_take     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A pixel lands in byte (y/8)*COLUMNS + x when both coordinates fall inside the store.
  assign req_page     = in_item_i.pixel_y[5:3];
  assign pix_in_range = ({2'b00, in_item_i.pixel_x} < 9'(COLUMNS)) &&
                        ({1'b0, req_page} < 4'(PAGES));
  assign req_pix_addr = AddrW'(int'(req_page) * COLUMNS + int'(in_item_i.pixel_x));

  // Data slots start after the three command slots of a page.
  assign tick_addr = AddrW'(int'(page_q) * COLUMNS + int'(slot_q) - 3);
  assign pix_mask  = 8'(1) << pix_bit_q;
  assign out_free  = !out_valid_q || out_ready_i;
  assign last_slot = (int'(slot_q) == Slots - 1);
  assign last_page = (int'(page_q) == PAGES - 1);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    sweep_d     = sweep_q;
    active_d    = active_q;
    page_d      = page_q;
    slot_d      = slot_q;
    pend_byte_d = pend_byte_q;
    pend_data_d = pend_data_q;
    pend_end_d  = pend_end_q;
    pix_addr_d  = pix_addr_q;
    pix_bit_d   = pix_bit_q;
    pix_color_d = pix_color_q;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = sweep_q;
    mem_wdata   = fill_q;

    case (state_q)
      // Clearing pass after reset, and the fill sweep: one byte per cycle.
      ST_SWEEP: begin
        mem_we   = 1'b1;
        mem_addr = sweep_q;
        if (int'(sweep_q) == Depth - 1) begin
          sweep_d = '0;
          state_d = ST_IDLE;
        end else begin
          sweep_d = sweep_q + AddrW'(1);
        end
      end

      ST_IDLE: begin
        if (in_take) begin
          case (in_item_i.command)
            CMD_WRITE_PIXEL: begin
              if (pix_in_range) begin
                mem_re      = 1'b1;
                mem_addr    = req_pix_addr;
                pix_addr_d  = req_pix_addr;
                pix_bit_d   = in_item_i.pixel_y[2:0];
                pix_color_d = in_item_i.color;
                state_d     = ST_PIX;
              end
            end
            CMD_FILL: begin
              fill_d   = in_item_i.color ? FillOnes : 8'h00;
              sweep_d  = '0;
              active_d = 1'b1;
              page_d   = '0;
              slot_d   = '0;
              state_d  = ST_SWEEP;
            end
            CMD_REFRESH: begin
              active_d = 1'b1;
              page_d   = '0;
              slot_d   = '0;
            end
            CMD_TICK: begin
              if (active_q) begin
                pend_data_d = 1'b0;
                pend_end_d  = 1'b0;
                case (slot_q)
                  SlotW'(0): pend_byte_d = page_base_q + 8'(page_q);
                  SlotW'(1): pend_byte_d = col_low_q;
                  SlotW'(2): pend_byte_d = col_high_q;
                  default: begin
                    pend_data_d = 1'b1;
                    mem_re      = 1'b1;
                    mem_addr    = tick_addr;
                  end
                endcase
                if (last_slot) begin
                  slot_d = '0;
                  if (last_page) begin
                    page_d     = '0;
                    active_d   = 1'b0;
                    pend_end_d = 1'b1;
                  end else begin
                    page_d = page_q + PageW'(1);
                  end
                end else begin
                  slot_d = slot_q + SlotW'(1);
                end
                state_d = ST_TICK;
              end
            end
            default: ;
          endcase
        end
      end

      // Read data of the addressed byte is here; set or clear the bit and write it back.
      ST_PIX: begin
        mem_we    = 1'b1;
        mem_addr  = pix_addr_q;
        mem_wdata = pix_color_q ? (rdata_q | pix_mask) : (rdata_q & ~pix_mask);
        state_d   = ST_IDLE;
      end

      // Hand the byte to the output register as soon as it is free.
      ST_TICK: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_item_d.out_byte  = pend_data_q ? rdata_q : pend_byte_q;
          out_item_d.is_data   = pend_data_q;
          out_item_d.frame_end = pend_end_q;
          state_d              = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      fill_q      <= 8'h00;
      sweep_q     <= '0;
      active_q    <= 1'b0;
      page_q      <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
      page_base_q <= PageCmdBaseRst;
      col_low_q   <= ColLowCmdRst;
      col_high_q  <= ColHighCmdRst;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      sweep_q     <= sweep_d;
      active_q    <= active_d;
      page_q      <= page_d;
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
      out_item_q  <= out_item_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_PAGE_CMD_BASE: page_base_q <= cfg_data_i;
          CFG_COL_LOW_CMD:   col_low_q   <= cfg_data_i;
          CFG_COL_HIGH_CMD:  col_high_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    pend_byte_q <= pend_byte_d;
    pend_data_q <= pend_data_d;
    pend_end_q  <= pend_end_d;
    pix_addr_q  <= pix_addr_d;
    pix_bit_q   <= pix_bit_d;
    pix_color_q <= pix_color_d;
  end

  // Frame store: one port, registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  a_frame_end_on_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.frame_end |-> out_item_o.is_data)
    else $error("frame end flagged on a command byte");

  a_fill_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && (in_item_i.command == CMD_FILL) |=> !in_ready_o)
    else $error("input taken right after a fill request");

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(slot_q) < Slots)
    else $error("slot counter beyond the last slot of a page");

  a_store_write_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_SWEEP) || (state_q == ST_PIX))
    else $error("store written outside a sweep or pixel update");

  a_idle_clears_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (slot_q == '0) && (page_q == '0))
    else $error("refresh counters not at rest while idle");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the page framebuffer refresh block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pfr_pkg::*;

  localparam int unsigned COLUMNS      = DefColumns;
  localparam int unsigned PAGES        = DefPages;
  localparam int unsigned CommandSlots = 3;
  // One complete refresh: three command bytes and a row of data bytes per page.
  localparam int unsigned FrameTicks   = PAGES * (CommandSlots + COLUMNS);
  // A fill sweeps the whole store, and the last refresh byte needs a margin on top.
  localparam int unsigned SweepSettle  = PAGES * COLUMNS + 16;
  localparam int unsigned TailSettle   = 16;
  localparam int unsigned DrainLimit   = 20_000;
  localparam int          RunLimitNs   = 6_000_000;

  // Index 3 has no register behind it, so writes to it must change nothing.
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  // One row of the bring-up table. When typed is set, want is the byte that the row must
  // produce, read straight off the register reset values, the pixels written before it, or the fill.
  typedef struct packed {
    in_item_t  req;
    logic      typed;
    out_item_t want;
  } stim_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [7:0] cfg_data_i;

  // Mirror of the block: frame store, refresh position and command registers.
  logic [7:0]  pixel_mirror [PAGES*COLUMNS];
  logic        mirror_refreshing;
  int unsigned mirror_page;
  int unsigned mirror_slot;
  logic [7:0]  mirror_page_base;
  logic [7:0]  mirror_col_low;
  logic [7:0]  mirror_col_high;

  // Bytes the block still owes the display, oldest first.
  out_item_t   expected_bytes [$];
  int unsigned mismatch_count  = 0;
  int unsigned delivered_bytes = 0;
  // Chance in percent, per request or per cycle, that a side starts an idle burst.
  int unsigned idle_pct        = 10;

  page_framebuffer_refresh_top #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #6;
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
  end

  function automatic in_item_t compose(input cmd_e cmd, input logic [6:0] x,
                                       input logic [5:0] y, input logic color);
    in_item_t req;
    req.command = cmd;
    req.pixel_x = x;
    req.pixel_y = y;
    req.color   = color;
    return req;
  endfunction

  function automatic stim_row_t mk_row(input cmd_e cmd, input logic [6:0] x,
                                       input logic [5:0] y, input logic color,
                                       input logic typed, input logic [7:0] data_byte,
                                       input logic is_data);
    stim_row_t row;
    row.req            = compose(cmd, x, y, color);
    row.typed          = typed;
    row.want.out_byte  = data_byte;
    row.want.is_data   = is_data;
    row.want.frame_end = 1'b0;
    return row;
  endfunction

  // Bring-up table, run with the registers at their reset values. It opens with
  // a tick while idle, touches the corner pixels, reads the first bytes of a
  // refresh, writes a pixel under a running refresh, restarts a refresh while
  // one runs, and fills the store both ways.
  localparam stim_row_t BringUpRows [23] = '{
    mk_row(CMD_TICK,        7'd0,   6'd0,  1'b1, 1'b0, 8'h00,          1'b0),
    mk_row(CMD_WRITE_PIXEL, 7'd0,   6'd0,  1'b1, 1'b0, 8'h00,          1'b0),
    mk_row(CMD_WRITE_PIXEL, 7'd127, 6'd63, 1'b1, 1'b0, 8'h00,          1'b0),
    mk_row(CMD_WRITE_PIXEL, 7'd127, 6'd63, 1'b0, 1'b0, 8'h00,          1'b0),
    mk_row(CMD_WRITE_PIXEL, 7'd127, 6'd63, 1'b1, 1'b0, 8'h00,          1'b0),
    mk_row(CMD_WRITE_PIXEL, 7'd85,  6'd42, 1'b1, 1'b0, 8'h00,          1'b0),
    mk_row(CMD_WRITE_PIXEL, 7'd42,  6'd21, 1'b0, 1'b0, 8'h00,          1'b0),
    mk_row(CMD_REFRESH,     7'd0,   6'd0,  1'b0, 1'b0, 8'h00,          1'b0),
    mk_row(CMD_TICK,        7'd0,   6'd0,  1'b0, 1'b1, PageCmdBaseRst, 1'b0),
    mk_row(CMD_TICK,        7'd0,   6'd0,  1'b0, 1'b1, ColLowCmdRst,   1'b0),
    mk_row(CMD_TICK,        7'd0,   6'd0,  1'b0, 1'b1, ColHighCmdRst,  1'b0),
    mk_row(CMD_TICK,        7'd0,   6'd0,  1'b0, 1'b1, 8'h01,          1'b1),
    mk_row(CMD_WRITE_PIXEL, 7'd1,   6'd7,  1'b1, 1'b0, 8'h00,          1'b0),
    mk_row(CMD_TICK,        7'd0,   6'd0,  1'b0, 1'b0, 8'h00,          1'b0),
    mk_row(CMD_REFRESH,     7'd0,   6'd0,  1'b1, 1'b0, 8'h00,          1'b0),
    mk_row(CMD_TICK,        7'd0,   6'd0,  1'b0, 1'b1, PageCmdBaseRst, 1'b0),
    mk_row(CMD_FILL,        7'd0,   6'd0,  1'b1, 1'b0, 8'h00,          1'b0),
    mk_row(CMD_TICK,        7'd0,   6'd0,  1'b0, 1'b1, PageCmdBaseRst, 1'b0),
    mk_row(CMD_TICK,        7'd0,   6'd0,  1'b0, 1'b1, ColLowCmdRst,   1'b0),
    mk_row(CMD_TICK,        7'd0,   6'd0,  1'b0, 1'b1, ColHighCmdRst,  1'b0),
    mk_row(CMD_TICK,        7'd0,   6'd0,  1'b0, 1'b1, FillOnes,       1'b1),
    mk_row(CMD_FILL,        7'd0,   6'd0,  1'b0, 1'b0, 8'h00,          1'b0),
    mk_row(CMD_TICK,        7'd0,   6'd0,  1'b0, 1'b1, PageCmdBaseRst, 1'b0)
  };

  // Applies one request to the mirror. Returns 1 when the request makes the
  // block send a byte, which is then left in res.
  function automatic logic predict_refresh_byte(input in_item_t req, output out_item_t res);
    int unsigned page;
    int unsigned col;
    res  = '0;
    page = req.pixel_y[5:3];
    case (cmd_e'(req.command))
      CMD_WRITE_PIXEL: begin
        // Pixels beyond the configured store are dropped.
        if (req.pixel_x < COLUMNS && page < PAGES) begin
          pixel_mirror[page*COLUMNS + req.pixel_x][req.pixel_y[2:0]] = req.color;
        end
      end
      CMD_FILL, CMD_REFRESH: begin
        if (cmd_e'(req.command) == CMD_FILL) begin
          foreach (pixel_mirror[i]) pixel_mirror[i] = req.color ? FillOnes : 8'h00;
        end
        // Starting again while a refresh runs goes back to page 0, slot 0.
        mirror_refreshing = 1'b1;
        mirror_page       = 0;
        mirror_slot       = 0;
      end
      CMD_TICK: begin
        if (mirror_refreshing && mirror_page < PAGES) begin
          if (mirror_slot == 0) begin
            res.out_byte = mirror_page_base + 8'(mirror_page);
          end else if (mirror_slot == 1) begin
            res.out_byte = mirror_col_low;
          end else if (mirror_slot == 2) begin
            res.out_byte = mirror_col_high;
          end else begin
            col = mirror_slot - CommandSlots;
            if (col >= COLUMNS) col = COLUMNS - 1;
            res.out_byte = pixel_mirror[mirror_page*COLUMNS + col];
            res.is_data  = 1'b1;
          end
          mirror_slot++;
          if (mirror_slot >= CommandSlots + COLUMNS) begin
            mirror_slot = 0;
            mirror_page++;
            if (mirror_page >= PAGES) begin
              mirror_page       = 0;
              mirror_refreshing = 1'b0;
              res.frame_end     = 1'b1;
            end
          end
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Random request: tick_pct percent ticks, start_pct percent fills or
  // refresh starts, the rest pixel writes. Every field is random throughout.
  function automatic in_item_t random_request(input int unsigned tick_pct,
                                              input int unsigned start_pct);
    int unsigned roll;
    cmd_e        cmd;
    roll = $urandom_range(0, 99);
    if (roll < tick_pct) begin
      cmd = CMD_TICK;
    end else if (roll < tick_pct + start_pct) begin
      cmd = $urandom_range(0, 1) ? CMD_FILL : CMD_REFRESH;
    end else begin
      cmd = CMD_WRITE_PIXEL;
    end
    return compose(cmd, 7'($urandom), 6'($urandom), 1'($urandom));
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Offers one request, after an optional idle burst, and holds it until ready is
  // seen high. The mirror is updated then, so every
  // expectation is queued before its byte can leave the output register.
  task automatic send_request(input in_item_t req, input logic typed, input out_item_t want);
    out_item_t predicted;
    logic      produced;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    produced = predict_refresh_byte(req, predicted);
    if (typed) begin
      predicted = want;
      produced  = 1'b1;
    end
    if (produced) expected_bytes.push_back(predicted);
  endtask

  // Writes all three command registers and pokes the unused index. Valid is
  // left high between back-to-back writes and dropped once at the end.
  task automatic program_registers(input logic [7:0] page_base, input logic [7:0] col_low,
                                   input logic [7:0] col_high, input logic [7:0] spare);
    logic [CfgIdxW-1:0] idx [4];
    logic [7:0]         value [4];
    idx   = '{CFG_PAGE_CMD_BASE, CFG_COL_LOW_CMD, CFG_COL_HIGH_CMD, CfgIdxSpare};
    value = '{page_base, col_low, col_high, spare};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= value[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (idx[i])
        CFG_PAGE_CMD_BASE: mirror_page_base = value[i];
        CFG_COL_LOW_CMD:   mirror_col_low   = value[i];
        CFG_COL_HIGH_CMD:  mirror_col_high  = value[i];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Stops offering requests, waits for every owed byte, then lets the block
  // settle. A fill can still be sweeping the store with nothing owed, which is
  // why register writes wait out a whole sweep.
  task automatic drain_and_settle(input int unsigned settle);
    int unsigned waited;
    in_valid_i <= 1'b0;
    waited = 0;
    while (expected_bytes.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_bytes.size() != 0) begin
      $error("%0d refresh bytes never arrived", expected_bytes.size());
      mismatch_count += expected_bytes.size();
      expected_bytes.delete();
    end
    repeat (settle) @(posedge clk_i);
  endtask

  // Output checker: every byte taken from the block is compared field by
  // field with the oldest owed byte.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      delivered_bytes <= delivered_bytes + 1;
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte 0x%0h (is_data %0b, frame_end %0b)",
               out_item_o.out_byte, out_item_o.is_data, out_item_o.frame_end);
        mismatch_count++;
      end else begin
        want = expected_bytes.pop_front();
        check_field("out_byte",  want.out_byte,  out_item_o.out_byte);
        check_field("is_data",   want.is_data,   out_item_o.is_data);
        check_field("frame_end", want.frame_end, out_item_o.frame_end);
      end
    end
  end

  // Display side. It stalls in short random bursts, and once, when a few
  // hundred bytes have gone by, it holds off for a long stretch so that the
  // output register stays full and the block has to stop taking ticks.
  initial begin : display_side
    int unsigned stall;
    logic        held_off;
    held_off = 1'b0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!held_off && delivered_bytes >= 300) begin
        held_off = 1'b1;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_ready_i <= 1'b0;
        stall = $urandom_range(1, 13);
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin : stimulus
    int unsigned ticks_sent;
    in_item_t    req;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_PAGE_CMD_BASE;
    cfg_data_i  <= 8'h00;
    foreach (pixel_mirror[i]) pixel_mirror[i] = 8'h00;
    mirror_refreshing = 1'b0;
    mirror_page       = 0;
    mirror_slot       = 0;
    mirror_page_base  = PageCmdBaseRst;
    mirror_col_low    = ColLowCmdRst;
    mirror_col_high   = ColHighCmdRst;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Bring-up rows; the first request waits out the clearing pass after reset.
    foreach (BringUpRows[i]) send_request(BringUpRows[i].req, BringUpRows[i].typed,
                                          BringUpRows[i].want);
    drain_and_settle(SweepSettle);

    // Full frame with the page base at its top, so the page command wraps
    // through zero. The store gets a random picture first, and pixels keep
    // changing while the frame goes out, down to its final byte.
    program_registers(8'hff, 8'h00, 8'hff, 8'($urandom));
    idle_pct <= 6;
    repeat (40) send_request(random_request(0, 0), 1'b0, '0);
    send_request(compose(CMD_REFRESH, 7'($urandom), 6'($urandom), 1'($urandom)), 1'b0, '0);
    ticks_sent = 0;
    while (ticks_sent < FrameTicks) begin
      req = random_request(94, 0);
      if (cmd_e'(req.command) == CMD_TICK) ticks_sent++;
      send_request(req, 1'b0, '0);
    end
    // The frame is done, so these ticks must produce nothing.
    repeat (4) send_request(random_request(100, 0), 1'b0, '0);
    drain_and_settle(SweepSettle);

    // Opposite register extremes, heavier idling, frequent restarts and fills.
    program_registers(8'h00, 8'hff, 8'h00, 8'($urandom));
    idle_pct <= 25;
    repeat (80) send_request(random_request(60, 8), 1'b0, '0);
    drain_and_settle(SweepSettle);

    // Random registers; the last stretch runs with neither side idling.
    program_registers(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    idle_pct <= 10;
    repeat (40) send_request(random_request(60, 8), 1'b0, '0);
    idle_pct <= 0;
    repeat (40) send_request(random_request(60, 8), 1'b0, '0);
    drain_and_settle(TailSettle);

    if (mismatch_count == 0) begin
      $display("page_framebuffer_refresh_top verification clean");
    end else begin
      $display("page_framebuffer_refresh_top verification failed");
    end
    $finish;
  end

  // Generous bound on the whole run, far beyond the slowest correct run.
  initial begin : watchdog
    #RunLimitNs;
    $display("page_framebuffer_refresh_top verification failed");
    $finish;
  end

endmodule
